### rtl/ilb_pkg.sv
// Shared constants, codes and types for the indexed list buffer.
package ilb_pkg;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned POS_W = 7;
  localparam int unsigned CNT_OUT_W = 7;
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_ERASE  = 2'd1,
    OP_READ   = 2'd2,
    OP_WRITE  = 2'd3
  } ilb_op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } ilb_status_e;

  typedef struct packed {
    ilb_op_e                   op;
    logic                      shifts;
    logic [POS_W-1:0]          pos;
    logic signed [DATA_W-1:0]  data;
  } ilb_cmd_t;

endpackage

### rtl/ilb_front.sv
// Input stage: registers each transaction and decodes it into a command.
module ilb_front import ilb_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [1:0]               opcode_i,
  input  logic [POS_W-1:0]         position_i,
  input  logic signed [DATA_W-1:0] data_in_i,
  output logic                     cmd_valid_o,
  input  logic                     cmd_stall_i,
  output ilb_cmd_t                 cmd_o
);

  logic     valid_q, valid_d;
  ilb_cmd_t cmd_q, cmd_d;
  logic     accept;

  assign in_stall_o = valid_q && cmd_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (valid_q && !cmd_stall_i) begin
      valid_d = 1'b0;
    end
    cmd_d.op     = ilb_op_e'(opcode_i);
    // Insert and erase move the cell row; read and write touch one entry.
    cmd_d.shifts = (cmd_d.op == OP_INSERT) || (cmd_d.op == OP_ERASE);
    cmd_d.pos    = position_i;
    cmd_d.data   = data_in_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_d;
    end
  end

  assign cmd_valid_o = valid_q;
  assign cmd_o       = cmd_q;

endmodule

### rtl/ilb_queue.sv
// Short command queue between the input stage and the execution stage.
module ilb_queue import ilb_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_valid_i,
  output logic     push_stall_o,
  input  ilb_cmd_t push_cmd_i,
  output logic     pop_valid_o,
  input  logic     pop_i,
  output ilb_cmd_t pop_cmd_o
);

  ilb_cmd_t            mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0]   fill_q, fill_d;
  logic                push, pop;

  assign push_stall_o = (fill_q == QCNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (fill_q != '0);
  assign push         = push_valid_i && !push_stall_o;
  assign pop          = pop_i && pop_valid_o;
  assign pop_cmd_o    = mem[rd_ptr_q];

  always_comb begin
    fill_d = fill_q;
    if (push && !pop) begin
      fill_d = fill_q + QCNT_W'(1);
    end else if (pop && !push) begin
      fill_d = fill_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      fill_q <= fill_d;
      if (push) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

### rtl/ilb_back.sv
// Execution stage: row of list cells, entry count and registered result.
module ilb_back import ilb_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cmd_valid_i,
  output logic                     cmd_pop_o,
  input  ilb_cmd_t                 cmd_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [DATA_W-1:0] data_out_o,
  output logic [1:0]               status_o,
  output logic [CNT_OUT_W-1:0]     entry_count_o
);

  logic signed [DATA_W-1:0] cells_q [CAPACITY];
  logic signed [DATA_W-1:0] cells_d [CAPACITY];
  logic [CNT_W-1:0]         count_q, count_d;
  logic                     out_valid_q, out_valid_d;
  logic signed [DATA_W-1:0] data_out_q, data_out_d;
  ilb_status_e              status_q, status_d;
  logic [CNT_OUT_W-1:0]     count_out_q;
  logic [CMP_W-1:0]         pos_ext, cnt_ext;
  logic                     take;
  logic                     ins_ok, era_ok, rd_ok, wr_ok;

  assign take      = cmd_valid_i && (!out_valid_q || !out_stall_i);
  assign cmd_pop_o = take;
  assign pos_ext   = CMP_W'(cmd_i.pos);
  assign cnt_ext   = CMP_W'(count_q);

  always_comb begin
    ins_ok   = 1'b0;
    era_ok   = 1'b0;
    rd_ok    = 1'b0;
    wr_ok    = 1'b0;
    status_d = ST_OK;
    if (cmd_i.op == OP_INSERT) begin
      // The range test takes priority over the full test.
      if (pos_ext > cnt_ext) begin
        status_d = ST_RANGE;
      end else if (count_q == CNT_W'(CAPACITY)) begin
        status_d = ST_FULL;
      end else begin
        ins_ok = take;
      end
    end else if (pos_ext >= cnt_ext) begin
      status_d = ST_RANGE;
    end else begin
      case (cmd_i.op)
        OP_ERASE: era_ok = take && cmd_i.shifts;
        OP_READ:  rd_ok  = take;
        OP_WRITE: wr_ok  = take;
        default:  status_d = ST_OK;
      endcase
    end
  end

  always_comb begin
    count_d = count_q;
    if (ins_ok) begin
      count_d = count_q + CNT_W'(1);
    end else if (era_ok) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic at_pos, after_pos;
    assign at_pos    = (CMP_W'(g) == pos_ext);
    assign after_pos = (CMP_W'(g) > pos_ext);

    always_comb begin
      cells_d[g] = cells_q[g];
      if ((ins_ok || wr_ok) && at_pos) begin
        cells_d[g] = cmd_i.data;
      end else if (ins_ok && after_pos) begin
        if (g > 0) begin
          cells_d[g] = cells_q[(g > 0) ? g - 1 : 0];
        end
      end else if (era_ok && (at_pos || after_pos)) begin
        if (g < CAPACITY - 1) begin
          cells_d[g] = cells_q[(g < CAPACITY - 1) ? g + 1 : g];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      cells_q[g] <= cells_d[g];
    end
  end

  always_comb begin
    data_out_d = '0;
    if (rd_ok) begin
      data_out_d = cells_q[IDX_W'(cmd_i.pos)];
    end
    out_valid_d = out_valid_q && out_stall_i;
    if (take) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      data_out_q  <= data_out_d;
      status_q    <= status_d;
      count_out_q <= CNT_OUT_W'(count_d);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign data_out_o    = data_out_q;
  assign status_o      = status_q;
  assign entry_count_o = count_out_q;

endmodule

### rtl/indexed_list_buffer_unit.sv
// Indexed list buffer: an ordered list of signed values addressed by position.
// Results pass the front stage register, the queue and the output register.
// Throughput: one transaction per cycle unless the output stalls; the cell
// row shifts a whole insert or erase at once; the execution stage never iterates.
// Reset: the entry count and all valid flags clear; list cells are not reset
// and hold no meaning until written, which no legal access can observe.
module indexed_list_buffer_unit import ilb_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // Input channel: one operation per transaction.
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [1:0]               opcode_i,
  input  logic [POS_W-1:0]         position_i,
  input  logic signed [DATA_W-1:0] data_in_i,
  // Output channel: one result per operation, in order.
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [DATA_W-1:0] data_out_o,
  output logic [1:0]               status_o,
  output logic [CNT_OUT_W-1:0]     entry_count_o
);

  // Front stage to queue.
  logic     fq_valid, fq_stall;
  ilb_cmd_t fq_cmd;

  // Queue to execution stage.
  logic     qb_valid, qb_pop;
  ilb_cmd_t qb_cmd;

  // The front stage registers each transaction and decodes its opcode. It
  // stalls the input only when its register is full and the queue cannot
  // take the command this cycle.
  ilb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .opcode_i    (opcode_i),
    .position_i  (position_i),
    .data_in_i   (data_in_i),
    .cmd_valid_o (fq_valid),
    .cmd_stall_i (fq_stall),
    .cmd_o       (fq_cmd)
  );

  // The queue decouples the two halves so that a stalled consumer backs up
  // into the queue before the input sees any stall.
  ilb_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fq_valid),
    .push_stall_o (fq_stall),
    .push_cmd_i   (fq_cmd),
    .pop_valid_o  (qb_valid),
    .pop_i        (qb_pop),
    .pop_cmd_o    (qb_cmd)
  );

  // The execution stage checks the position against the live entry count,
  // updates the cell row and count, and registers the result. It takes a new
  // command whenever its output register is empty or being drained.
  ilb_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (qb_valid),
    .cmd_pop_o     (qb_pop),
    .cmd_i         (qb_cmd),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .data_out_o    (data_out_o),
    .status_o      (status_o),
    .entry_count_o (entry_count_o)
  );

endmodule
